>>> sv/stok_pkg.sv
// types, constants and helper functions for the source tokenizer
// no dependencies; imported by every stok module and the top level
package stok_pkg;

  localparam int MAX_TOKEN_LEN = 255;
  localparam int POSITION_BITS = 16;
  localparam int OFFSET_BITS   = 24;

  localparam int LEN_BITS    = $clog2(MAX_TOKEN_LEN + 1);
  localparam int POS_EXT     = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int OFF_EXT     = (OFFSET_BITS > 24) ? OFFSET_BITS : 24;
  localparam int LEN_EXT     = (LEN_BITS > 8) ? LEN_BITS : 8;
  localparam int NUM_KW      = 9;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // scan modes
  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_NUMBER = 3'd2;
  localparam logic [2:0] MODE_BANG   = 3'd3;
  localparam logic [2:0] MODE_GT     = 3'd4;
  localparam logic [2:0] MODE_LT     = 3'd5;
  localparam logic [2:0] MODE_EQ     = 3'd6;

  // token kinds
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_KW0    = 5'd3;
  localparam logic [4:0] KIND_PLUS   = 5'd12;
  localparam logic [4:0] KIND_MINUS  = 5'd13;
  localparam logic [4:0] KIND_STAR   = 5'd14;
  localparam logic [4:0] KIND_SLASH  = 5'd15;
  localparam logic [4:0] KIND_PCT    = 5'd16;
  localparam logic [4:0] KIND_COMMA  = 5'd17;
  localparam logic [4:0] KIND_SEMI   = 5'd18;
  localparam logic [4:0] KIND_LPAREN = 5'd19;
  localparam logic [4:0] KIND_RPAREN = 5'd20;
  localparam logic [4:0] KIND_LBRACE = 5'd21;
  localparam logic [4:0] KIND_RBRACE = 5'd22;
  localparam logic [4:0] KIND_BANG   = 5'd23;
  localparam logic [4:0] KIND_NE     = 5'd24;
  localparam logic [4:0] KIND_GT     = 5'd25;
  localparam logic [4:0] KIND_GE     = 5'd26;
  localparam logic [4:0] KIND_LT     = 5'd27;
  localparam logic [4:0] KIND_LE     = 5'd28;
  localparam logic [4:0] KIND_ASSIGN = 5'd29;
  localparam logic [4:0] KIND_EQEQ   = 5'd30;
  localparam logic [4:0] KIND_NONE   = 5'd0;
  localparam logic [4:0] KIND_ERROR  = 5'd31;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  // keyword text, right-aligned string literals
  localparam logic [63:0] KW_STR [NUM_KW] = '{
    64'("require"), 64'("if"), 64'("else"), 64'("return"), 64'("loop"),
    64'("let"), 64'("fn"), 64'("and"), 64'("or")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd7, 4'd2, 4'd4, 4'd6, 4'd4, 4'd3, 4'd2, 4'd3, 4'd2
  };

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [23:0] offset;
    logic [7:0]  length;
    logic        last;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } rec_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // byte p of keyword k, valid for p below its length
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] p);
    logic [2:0] idx;
    idx = 3'(KW_LEN[k] - 4'd1 - {1'b0, p});
    return KW_STR[k][{idx, 3'b000} +: 8];
  endfunction

  // mask of keywords still matching after character c at position p
  function automatic logic [NUM_KW-1:0] kw_keep(input logic [7:0] c,
                                                input logic [LEN_BITS-1:0] p);
    logic [NUM_KW-1:0] keep;
    for (int k = 0; k < NUM_KW; k++) begin
      keep[k] = (p < LEN_BITS'(KW_LEN[k])) && (kw_char(k, p[2:0]) == c);
    end
    return keep;
  endfunction

  function automatic logic [4:0] single_op(input logic [7:0] c);
    logic [4:0] kind;
    unique case (c)
      8'h2B:   kind = KIND_PLUS;
      8'h2D:   kind = KIND_MINUS;
      8'h2A:   kind = KIND_STAR;
      8'h2F:   kind = KIND_SLASH;
      8'h25:   kind = KIND_PCT;
      8'h2C:   kind = KIND_COMMA;
      8'h3B:   kind = KIND_SEMI;
      8'h28:   kind = KIND_LPAREN;
      8'h29:   kind = KIND_RPAREN;
      8'h7B:   kind = KIND_LBRACE;
      8'h7D:   kind = KIND_RBRACE;
      default: kind = KIND_NONE;
    endcase
    return kind;
  endfunction

  function automatic logic [15:0] clamp_pos(input logic [POSITION_BITS-1:0] v);
    logic [POS_EXT-1:0] ext;
    ext = POS_EXT'(v);
    return (ext > POS_EXT'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic [23:0] clamp_off(input logic [OFFSET_BITS-1:0] v);
    logic [OFF_EXT-1:0] ext;
    ext = OFF_EXT'(v);
    return (ext > OFF_EXT'(24'hFFFFFF)) ? 24'hFFFFFF : ext[23:0];
  endfunction

  function automatic logic [7:0] clamp_len(input logic [LEN_BITS-1:0] v);
    logic [LEN_EXT-1:0] ext;
    ext = LEN_EXT'(v);
    return (ext > LEN_EXT'(8'hFF)) ? 8'hFF : ext[7:0];
  endfunction

endpackage

>>> sv/stok_scan.sv
// front part: classifies each accepted character and keeps scan state
// produces a record of up to two tokens per item; uses stok_pkg
module stok_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic [7:0]      src_char,
  input  logic            src_end,
  output logic            push,
  output stok_pkg::rec_t  rec
);
  import stok_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [OFFSET_BITS-1:0]   OFF_MAX = '1;
  localparam logic [LEN_BITS-1:0]      LEN_MAX = LEN_BITS'(MAX_TOKEN_LEN);
  localparam logic [NUM_KW-1:0]        KW_ALL  = '1;

  logic [2:0]               mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt, col_r, col_nxt;
  logic [OFFSET_BITS-1:0]   off_r, off_nxt;
  logic [POSITION_BITS-1:0] sline_r, sline_nxt, scol_r, scol_nxt;
  logic [OFFSET_BITS-1:0]   soff_r, soff_nxt;
  logic [LEN_BITS-1:0]      len_r, len_nxt;
  logic [NUM_KW-1:0]        kw_r, kw_nxt;
  logic                     halted_r, halted_nxt;

  logic       op_mode;
  logic       flush_valid;
  tok_t       flush_tok;
  logic [4:0] pend_kind;
  logic [4:0] ident_kind;
  logic       new_valid;
  tok_t       new_tok;
  tok_t       end_tok;
  tok_t       dbl_tok;
  logic [4:0] sop;

  assign op_mode = (mode_r >= MODE_BANG) && (mode_r <= MODE_EQ);
  assign sop     = single_op(src_char);

  always_comb begin
    unique case (mode_r)
      MODE_BANG: pend_kind = KIND_BANG;
      MODE_GT:   pend_kind = KIND_GT;
      MODE_LT:   pend_kind = KIND_LT;
      default:   pend_kind = KIND_ASSIGN;
    endcase
  end

  // later keyword wins, as in the sequential check
  always_comb begin
    ident_kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (kw_r[k] && (len_r == LEN_BITS'(KW_LEN[k]))) begin
        ident_kind = KIND_KW0 + 5'(k);
      end
    end
  end

  always_comb begin
    flush_valid      = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER) || op_mode;
    flush_tok.kind   = (mode_r == MODE_IDENT) ? ident_kind :
                       (mode_r == MODE_NUMBER) ? KIND_NUMBER : pend_kind;
    flush_tok.line   = clamp_pos(sline_r);
    flush_tok.column = clamp_pos(scol_r);
    flush_tok.offset = clamp_off(soff_r);
    flush_tok.length = clamp_len(len_r);
    flush_tok.last   = 1'b0;

    end_tok.kind   = KIND_END;
    end_tok.line   = clamp_pos(line_r);
    end_tok.column = clamp_pos(col_r);
    end_tok.offset = clamp_off(off_r);
    end_tok.length = 8'd0;
    end_tok.last   = 1'b1;

    // two-character comparison: the pending kind plus one
    dbl_tok        = flush_tok;
    dbl_tok.kind   = pend_kind + 5'd1;
    dbl_tok.length = 8'd2;
    dbl_tok.last   = 1'b1;

    new_tok        = end_tok;
    new_tok.kind   = (sop != KIND_NONE) ? sop : KIND_ERROR;
    new_tok.length = 8'd1;
  end

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    off_nxt    = off_r;
    sline_nxt  = sline_r;
    scol_nxt   = scol_r;
    soff_nxt   = soff_r;
    len_nxt    = len_r;
    kw_nxt     = kw_r;
    halted_nxt = halted_r;
    push       = 1'b0;
    rec        = '0;
    new_valid  = 1'b0;

    if (accept && !halted_r) begin
      if (src_end) begin
        push     = 1'b1;
        mode_nxt = MODE_IDLE;
        kw_nxt   = KW_ALL;
        if (flush_valid) begin
          rec.two  = 1'b1;
          rec.tok0 = flush_tok;
          rec.tok1 = end_tok;
        end else begin
          rec.tok0 = end_tok;
        end
      end else begin
        // advance position for every character
        off_nxt = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;
        if (src_char == CH_NL) begin
          line_nxt = (line_r == POS_MAX) ? line_r : line_r + 1'b1;
          col_nxt  = '0;
        end else begin
          col_nxt = (col_r == POS_MAX) ? col_r : col_r + 1'b1;
        end

        priority if (mode_r == MODE_IDENT && (is_letter(src_char) || is_digit(src_char))) begin
          kw_nxt  = kw_r & kw_keep(src_char, len_r);
          len_nxt = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
        end else if (mode_r == MODE_NUMBER && is_digit(src_char)) begin
          len_nxt = (len_r == LEN_MAX) ? len_r : len_r + 1'b1;
        end else if (op_mode && src_char == CH_EQ) begin
          push     = 1'b1;
          rec.tok0 = dbl_tok;
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_IDLE;
          if (flush_valid) begin
            kw_nxt = KW_ALL;
          end
          // character seen from idle
          priority if (src_char == CH_SPACE || src_char == CH_TAB || src_char == CH_NL) begin
            new_valid = 1'b0;
          end else if (is_letter(src_char) || is_digit(src_char) ||
                       src_char == CH_BANG || src_char == CH_GT ||
                       src_char == CH_LT || src_char == CH_EQ) begin
            sline_nxt = line_r;
            scol_nxt  = col_r;
            soff_nxt  = off_r;
            len_nxt   = LEN_BITS'(1);
            priority if (is_letter(src_char)) begin
              mode_nxt = MODE_IDENT;
              kw_nxt   = KW_ALL & kw_keep(src_char, '0);
            end else if (is_digit(src_char)) begin
              mode_nxt = MODE_NUMBER;
            end else if (src_char == CH_BANG) begin
              mode_nxt = MODE_BANG;
            end else if (src_char == CH_GT) begin
              mode_nxt = MODE_GT;
            end else if (src_char == CH_LT) begin
              mode_nxt = MODE_LT;
            end else begin
              mode_nxt = MODE_EQ;
            end
          end else begin
            new_valid = 1'b1;
            if (sop == KIND_NONE) begin
              halted_nxt = 1'b1;
            end
          end

          push = flush_valid || new_valid;
          if (flush_valid && new_valid) begin
            rec.two  = 1'b1;
            rec.tok0 = flush_tok;
            rec.tok1 = new_tok;
          end else if (flush_valid) begin
            rec.tok0      = flush_tok;
            rec.tok0.last = 1'b1;
          end else begin
            rec.tok0 = new_tok;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      line_r   <= '0;
      col_r    <= '0;
      off_r    <= '0;
      sline_r  <= '0;
      scol_r   <= '0;
      soff_r   <= '0;
      len_r    <= '0;
      kw_r     <= KW_ALL;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      off_r    <= off_nxt;
      sline_r  <= sline_nxt;
      scol_r   <= scol_nxt;
      soff_r   <= soff_nxt;
      len_r    <= len_nxt;
      kw_r     <= kw_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> sv/stok_queue.sv
// short record queue between the scanner and the output stage
// depth from stok_pkg::QUEUE_DEPTH; uses stok_pkg
module stok_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  stok_pkg::rec_t  push_rec,
  input  logic            pop,
  output stok_pkg::rec_t  head,
  output logic            not_empty,
  output logic            full
);
  import stok_pkg::*;

  rec_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   count_r, count_nxt;
  logic                 do_push, do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign head      = mem[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_BITS + 1)'(do_push) - (QPTR_BITS + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/stok_emit.sv
// back part: splits queued records into single tokens on the output channel
// holds one registered token; uses stok_pkg
module stok_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  stok_pkg::rec_t  head,
  input  logic            not_empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output stok_pkg::tok_t  out_tok
);
  import stok_pkg::*;

  logic valid_r, valid_nxt;
  logic sub_r, sub_nxt;
  tok_t tok_r, tok_nxt;
  logic load;

  assign load      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_tok   = tok_r;

  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    tok_nxt   = tok_r;
    pop       = 1'b0;
    if (load) begin
      valid_nxt = not_empty;
      if (not_empty) begin
        tok_nxt = sub_r ? head.tok1 : head.tok0;
        // pop once the last token of the record is taken; else the second token of a pair is still to come
        if (sub_r || !head.two) begin
          pop     = 1'b1;
          sub_nxt = 1'b0;
        end else begin
          sub_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

>>> sv/source_tokenizer_top.sv
// source tokenizer: one character per cycle in while the queue is not full,
// one token per cycle out while out_tready is high; a token is written to the
// record queue, then the output register behind out_tvalid; an item that
// yields two tokens puts them out in turn, absorbed by a four-record queue
// reset: synchronous, active low; clears position counters, scan state and queue
module source_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_char
  input  logic        in_tuser,   // [0] end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [4:0] kind, [20:5] line, [36:21] column,
                                  // [60:37] offset, [68:61] length, [71:69] zero
  output logic        out_tlast
);
  import stok_pkg::*;

  logic accept;
  logic push;
  rec_t push_rec;
  rec_t head;
  logic not_empty;
  logic full;
  logic pop;
  tok_t tok;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  stok_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .src_char (in_tdata),
    .src_end  (in_tuser),
    .push     (push),
    .rec      (push_rec)
  );

  stok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  stok_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  assign out_tdata = {3'b000, tok.length, tok.offset, tok.column, tok.line, tok.kind};
  assign out_tlast = tok.last;

endmodule

>>> tb/tb_top.sv
// testbench for source_tokenizer_top: streams characters and end marks, predicts
// every token in a scoreboard class and checks each output item against it
// depends on stok_pkg for the token record type, kinds, modes and char codes
`timescale 1ns / 1ps

module tb_top;
  import stok_pkg::*;

  // token predictor and checker; holds its own copy of the scan state
  class token_checker;
    tok_t              tokens_due[$];
    tok_t              step_toks[$];
    int                fails;
    string             kw_words[NUM_KW];
    logic [2:0]        mode;
    logic [15:0]       line_cnt, col_cnt, st_line, st_col;
    logic [23:0]       off_cnt, st_off;
    int unsigned       tok_len;
    logic [NUM_KW-1:0] kw_live;
    bit                halted;

    function new();
      kw_words = '{"require", "if", "else", "return", "loop", "let", "fn", "and", "or"};
      mode     = MODE_IDLE;
      line_cnt = '0;
      col_cnt  = '0;
      off_cnt  = '0;
      st_line  = '0;
      st_col   = '0;
      st_off   = '0;
      tok_len  = 0;
      kw_live  = '1;
      halted   = 1'b0;
      fails    = 0;
    endfunction

    function bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function logic [4:0] plain_op_kind(logic [7:0] c);
      case (c)
        "+":     return KIND_PLUS;
        "-":     return KIND_MINUS;
        "*":     return KIND_STAR;
        "/":     return KIND_SLASH;
        "%":     return KIND_PCT;
        ",":     return KIND_COMMA;
        ";":     return KIND_SEMI;
        "(":     return KIND_LPAREN;
        ")":     return KIND_RPAREN;
        "{":     return KIND_LBRACE;
        "}":     return KIND_RBRACE;
        default: return KIND_NONE;
      endcase
    endfunction

    function tok_t make_tok(logic [4:0] kind, logic [15:0] ln, logic [15:0] col,
                            logic [23:0] off, logic [7:0] len);
      tok_t t;
      t.kind   = kind;
      t.line   = ln;
      t.column = col;
      t.offset = off;
      t.length = len;
      t.last   = 1'b0;
      return t;
    endfunction

    // append one predicted token for the current item
    function void queue_tok(tok_t t);
      step_toks.insert(step_toks.size(), t);
    endfunction

    // drop keywords that cannot match character c at position p
    function void narrow_keywords(logic [7:0] c, int unsigned p);
      for (int k = 0; k < NUM_KW; k++) begin
        if (p >= kw_words[k].len() || 8'(kw_words[k][p]) != c) kw_live[k] = 1'b0;
      end
    endfunction

    function void step_position(logic [7:0] c);
      if (off_cnt != '1) off_cnt++;
      if (c == CH_NL) begin
        if (line_cnt != '1) line_cnt++;
        col_cnt = '0;
      end else if (col_cnt != '1) begin
        col_cnt++;
      end
    endfunction

    function void begin_scan(logic [2:0] m);
      mode    = m;
      st_line = line_cnt;
      st_col  = col_cnt;
      st_off  = off_cnt;
      tok_len = 1;
    endfunction

    function void flush_pending();
      logic [4:0] kind;
      case (mode)
        MODE_IDENT: begin
          kind = KIND_IDENT;
          for (int k = 0; k < NUM_KW; k++) begin
            if (kw_live[k] && kw_words[k].len() == tok_len) kind = KIND_KW0 + 5'(k);
          end
        end
        MODE_NUMBER: kind = KIND_NUMBER;
        MODE_BANG:   kind = KIND_BANG;
        MODE_GT:     kind = KIND_GT;
        MODE_LT:     kind = KIND_LT;
        MODE_EQ:     kind = KIND_ASSIGN;
        default: begin
          mode = MODE_IDLE;
          return;
        end
      endcase
      queue_tok(make_tok(kind, st_line, st_col, st_off, 8'(tok_len)));
      mode    = MODE_IDLE;
      kw_live = '1;
    endfunction

    function logic [4:0] pair_kind(logic [2:0] m);
      case (m)
        MODE_BANG: return KIND_NE;
        MODE_GT:   return KIND_GE;
        MODE_LT:   return KIND_LE;
        default:   return KIND_EQEQ;
      endcase
    endfunction

    function void scan_char(logic [7:0] c);
      logic [4:0] op;
      if (mode == MODE_IDENT) begin
        if (letter(c) || digit(c)) begin
          narrow_keywords(c, tok_len);
          if (tok_len < MAX_TOKEN_LEN) tok_len++;
          step_position(c);
          return;
        end
        flush_pending();
      end else if (mode == MODE_NUMBER) begin
        if (digit(c)) begin
          if (tok_len < MAX_TOKEN_LEN) tok_len++;
          step_position(c);
          return;
        end
        flush_pending();
      end else if (mode != MODE_IDLE) begin
        if (c == CH_EQ) begin
          queue_tok(make_tok(pair_kind(mode), st_line, st_col, st_off, 8'd2));
          mode = MODE_IDLE;
          step_position(c);
          return;
        end
        flush_pending();
      end
      // the character now starts from idle
      op = plain_op_kind(c);
      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
        // separators only move the position
      end else if (letter(c)) begin
        begin_scan(MODE_IDENT);
        kw_live = '1;
        narrow_keywords(c, 0);
      end else if (digit(c)) begin
        begin_scan(MODE_NUMBER);
      end else if (c == CH_BANG) begin
        begin_scan(MODE_BANG);
      end else if (c == CH_GT) begin
        begin_scan(MODE_GT);
      end else if (c == CH_LT) begin
        begin_scan(MODE_LT);
      end else if (c == CH_EQ) begin
        begin_scan(MODE_EQ);
      end else if (op != KIND_NONE) begin
        queue_tok(make_tok(op, line_cnt, col_cnt, off_cnt, 8'd1));
      end else begin
        queue_tok(make_tok(KIND_ERROR, line_cnt, col_cnt, off_cnt, 8'd1));
        halted = 1'b1;
      end
      step_position(c);
    endfunction

    // accepted input item: predict the tokens it causes
    function void note_item(logic [7:0] c, logic eos);
      step_toks.delete();
      if (halted) return;
      if (eos) begin
        flush_pending();
        queue_tok(make_tok(KIND_END, line_cnt, col_cnt, off_cnt, 8'd0));
      end else begin
        scan_char(c);
      end
      if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
      tokens_due = {tokens_due, step_toks};
    endfunction

    function void field_check(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        fails++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_token(tok_t got);
      tok_t want;
      if (tokens_due.size() == 0) begin
        fails++;
        $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
                 $time, got.kind, got.offset);
        return;
      end
      want = tokens_due.pop_front();
      field_check("kind", want.kind, got.kind);
      field_check("line", want.line, got.line);
      field_check("column", want.column, got.column);
      field_check("offset", want.offset, got.offset);
      field_check("length", want.length, got.length);
      field_check("last", want.last, got.last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;

  token_checker sb;
  int          items_sent;
  bit          tx_gaps;
  bit          rx_gaps;
  bit          hold_off_req;

  string letters    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string digits     = "0123456789";
  string single_ops = "+-*/%,;(){}";
  string pend_ops   = "!><=";
  string seps       = " \t\n";
  string alnum;
  string valid_chars;

  source_tokenizer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin : monitor
    tok_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.kind   = out_tdata[4:0];
        got.line   = out_tdata[20:5];
        got.column = out_tdata[36:21];
        got.offset = out_tdata[60:37];
        got.length = out_tdata[68:61];
        got.last   = out_tlast;
        sb.check_token(got);
      end
      if (in_tvalid && in_tready) sb.note_item(in_tdata, in_tuser);
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready = 1'b0;
        repeat (300) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(0, 14)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  task automatic send_item(logic [7:0] c, logic eos);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = c;
    in_tuser  = eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // the character byte is don't-care on an end mark, so any value goes
  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic bit known_char(logic [7:0] c);
    for (int i = 0; i < valid_chars.len(); i++) begin
      if (8'(valid_chars[i]) == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // one random piece of source, mostly well-formed tokens
  task automatic send_piece();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_text(sb.kw_words[$urandom_range(0, NUM_KW - 1)]);
    end else if (r < 45) begin
      n = $urandom_range(1, 8);
      send_item(pick(letters), 1'b0);
      repeat (n - 1) send_item(pick(alnum), 1'b0);
    end else if (r < 58) begin
      repeat ($urandom_range(1, 6)) send_item(pick(digits), 1'b0);
    end else if (r < 78) begin
      if ($urandom_range(0, 1)) begin
        send_item(pick(single_ops), 1'b0);
      end else begin
        send_item(pick(pend_ops), 1'b0);
        if ($urandom_range(0, 1)) send_item(CH_EQ, 1'b0);
      end
    end else if (r < 88) begin
      repeat ($urandom_range(1, 3)) send_item(pick(seps), 1'b0);
    end else if (r < 94) begin
      repeat ($urandom_range(1, 4)) send_item(pick(valid_chars), 1'b0);
    end else if (r < 97) begin
      send_end();
    end else begin
      // token cut short by an end mark
      send_item($urandom_range(0, 1) ? pick(pend_ops) : pick(letters), 1'b0);
      send_end();
    end
    if ($urandom_range(0, 9) < 6) send_item(pick(seps), 1'b0);
  endtask

  initial begin
    logic [7:0] bad;
    int start;
    sb           = new();
    alnum        = {letters, digits};
    valid_chars  = {letters, digits, single_ops, pend_ops, seps};
    items_sent   = 0;
    tx_gaps      = 1'b1;
    rx_gaps      = 1'b1;
    hold_off_req = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: terminating chars, pending ops with and without '=', end then more source
    send_text("_Az9+09;!a<=b\t=\n");
    send_end();
    send_text("zz");
    send_end();

    // random source; the receiver holds off first so the queue backs up
    hold_off_req = 1'b1;
    start = items_sent;
    while (items_sent - start < 850) begin
      tx_gaps = ((items_sent - start) / 200) % 2 == 0;
      rx_gaps = ((items_sent - start) / 150) % 3 != 1;
      send_piece();
    end

    // no idling from here on: saturating token lengths
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_item(pick(letters), 1'b0);
    repeat (259) send_item(pick(alnum), 1'b0);
    send_item(CH_SPACE, 1'b0);
    repeat (258) send_item(pick(digits), 1'b0);
    send_item(CH_BANG, 1'b0);
    send_end();

    // unknown byte halts the block; nothing comes out afterwards
    do bad = 8'($urandom_range(0, 255)); while (known_char(bad));
    send_item(bad, 1'b0);
    send_text("a b;");
    send_end();

    while (sb.tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/stok_pkg.sv
sv/stok_scan.sv
sv/stok_queue.sv
sv/stok_emit.sv
sv/source_tokenizer_top.sv
tb/tb_top.sv
